/* rtl/core/crcdl_pkg.sv */
`timescale 1ns / 1ps

package crcdl_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'h0000;
  localparam logic [3:0] AttemptsReset = 4'd5;

  localparam logic ModeByte = 1'b0;
  localparam logic ModeReadback = 1'b1;

  typedef enum logic [2:0] {
    ST_SEND        = 3'd0,
    ST_ACCEPTED    = 3'd1,
    ST_RESEND      = 3'd2,
    ST_FAILED      = 3'd3,
    ST_OUT_OF_TURN = 3'd4
  } status_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        last_of_line;
    logic        final_line;
    logic [15:0] readback_crc;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] expected_crc;
    logic [9:0]  send_length;
    logic [3:0]  attempt_count;
  } out_item_t;

  // one byte folded into crc-16/xmodem, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/crcdl_in_if.sv */
`timescale 1ns / 1ps

interface crcdl_in_if;
  logic               valid;
  logic               ready;
  crcdl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/crcdl_out_if.sv */
`timescale 1ns / 1ps

interface crcdl_out_if;
  logic                valid;
  logic                ready;
  crcdl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/crc_checked_download_verifier_core.sv */
`timescale 1ns / 1ps

// download line verifier with crc-16/xmodem (poly 0x1021, init 0, no reflection)
// in_i carries one transaction per line byte (mode 0, command byte first) or
// per crc readback from the device (mode 1). out_o carries at most one result
// per input transaction: send line (failed if over-long) at line end, then accepted / resend / failed
// for each readback, or out of turn for an item that does not fit the state.
// cfg_we_i / cfg_wdata_i write max_attempts (reset 5); the user must write it
// only while the block is idle, the block itself does not enforce this. one
// transaction per cycle is taken while out_o is not stalled; the byte-wide crc
// update and the trim bookkeeping sit between the accepted item and the result
// register, so a result appears on out_o in the cycle after its input transaction.
// the single result register is the only buffer: while out_o is stalled with a
// result pending, in_i.ready is low; it rises again in the cycle the result is
// taken, so a streaming receiver sees full rate. reset clears all line state and
// the result valid flag and loads max_attempts with 5; no clearing pass is needed.
module crc_checked_download_verifier_core #(
  parameter int MAX_LINE_BYTES = 1024,
  parameter int GROUP_SIZE     = 5,
  parameter int HEADER_BYTES   = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  crcdl_in_if.sink   in_i,
  crcdl_out_if.source out_o
);

  localparam int CntW = $clog2(MAX_LINE_BYTES + 2);
  localparam int GrpW = $clog2(GROUP_SIZE + 1);

  logic [3:0]      max_att_q;
  logic [15:0]     crc_run_q, crc_run_d;
  logic [15:0]     crc_conf_q, crc_conf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] conf_len_q, conf_len_d;
  logic [GrpW-1:0] grp_pos_q, grp_pos_d;
  logic            grp_nz_q, grp_nz_d;
  logic            trim_q, trim_d;
  logic            await_q, await_d;
  logic [3:0]      att_q, att_d;
  logic            final_q, final_d;

  logic                 out_valid_q, out_valid_d;
  crcdl_pkg::out_item_t out_data_q, out_data_d;

  logic                 in_fire;
  logic                 emit;
  crcdl_pkg::out_item_t res;
  crcdl_pkg::in_item_t  it;
  logic [CntW-1:0]      plen;
  logic [CntW+9:0]      plen_ext;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign it         = in_i.data;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    crc_run_d  = crc_run_q;
    crc_conf_d = crc_conf_q;
    cnt_d      = cnt_q;
    conf_len_d = conf_len_q;
    grp_pos_d  = grp_pos_q;
    grp_nz_d   = grp_nz_q;
    trim_d     = trim_q;
    await_d    = await_q;
    att_d      = att_q;
    final_d    = final_q;
    emit       = 1'b0;
    plen       = (conf_len_q != '0) ? conf_len_q - 1'b1 : '0;
    plen_ext   = {10'b0, plen};
    res.status        = crcdl_pkg::ST_OUT_OF_TURN;
    res.expected_crc  = '0;
    res.send_length   = '0;
    res.attempt_count = att_q;

    if (it.mode == crcdl_pkg::ModeByte) begin
      if (await_q) begin
        emit = 1'b1;
      end else begin
        if (cnt_q == '0) begin
          final_d = it.final_line;
        end
        if (32'(cnt_q) <= MAX_LINE_BYTES) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (!trim_q) begin
          crc_run_d = crcdl_pkg::crc_byte(crc_run_q, it.data_byte);
          if (!final_d || (32'(cnt_q) < HEADER_BYTES)) begin
            crc_conf_d = crc_run_d;
            conf_len_d = cnt_d;
          end else begin
            grp_pos_d = grp_pos_q + 1'b1;
            grp_nz_d  = grp_nz_q || (it.data_byte != 8'h00);
            if (32'(grp_pos_d) >= GROUP_SIZE) begin
              if (grp_nz_d) begin
                crc_conf_d = crc_run_d;
                conf_len_d = cnt_d;
              end else begin
                trim_d = 1'b1;
              end
              grp_pos_d = '0;
              grp_nz_d  = 1'b0;
            end
          end
        end
        if (it.last_of_line) begin
          emit = 1'b1;
          // a trailing partial group stays in the counted part
          if (!trim_d && (grp_pos_d != '0)) begin
            crc_conf_d = crc_run_d;
            conf_len_d = cnt_d;
          end
          if (32'(cnt_d) > MAX_LINE_BYTES) begin
            res.status        = crcdl_pkg::ST_FAILED;
            res.attempt_count = '0;
            await_d = 1'b1;  // cleared below with the rest of the line
          end else begin
            plen     = (conf_len_d != '0) ? conf_len_d - 1'b1 : '0;
            plen_ext = {10'b0, plen};
            await_d = 1'b1;
            att_d   = 4'd1;
            res.status        = crcdl_pkg::ST_SEND;
            res.expected_crc  = crc_conf_d;
            res.send_length   = plen_ext[9:0];
            res.attempt_count = 4'd1;
          end
        end
      end
    end else begin
      emit = 1'b1;
      if (await_q) begin
        res.expected_crc  = crc_conf_q;
        res.send_length   = plen_ext[9:0];
        res.attempt_count = att_q;
        if (it.readback_crc == crc_conf_q) begin
          res.status = crcdl_pkg::ST_ACCEPTED;
        end else if (att_q < max_att_q) begin
          res.status        = crcdl_pkg::ST_RESEND;
          att_d             = att_q + 1'b1;
          res.attempt_count = att_d;
        end else begin
          res.status = crcdl_pkg::ST_FAILED;
        end
      end
    end

    // line ends in accepted or failed: start the next line from scratch
    if (emit && (res.status == crcdl_pkg::ST_ACCEPTED || res.status == crcdl_pkg::ST_FAILED)) begin
      crc_run_d  = crcdl_pkg::CrcInit;
      crc_conf_d = crcdl_pkg::CrcInit;
      cnt_d      = '0;
      conf_len_d = '0;
      grp_pos_d  = '0;
      grp_nz_d   = 1'b0;
      trim_d     = 1'b0;
      await_d    = 1'b0;
      att_d      = '0;
      final_d    = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d = emit;
      if (emit) begin
        out_data_d = res;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q   <= crcdl_pkg::AttemptsReset;
      crc_run_q   <= crcdl_pkg::CrcInit;
      crc_conf_q  <= crcdl_pkg::CrcInit;
      cnt_q       <= '0;
      conf_len_q  <= '0;
      grp_pos_q   <= '0;
      grp_nz_q    <= 1'b0;
      trim_q      <= 1'b0;
      await_q     <= 1'b0;
      att_q       <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_att_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        crc_run_q  <= crc_run_d;
        crc_conf_q <= crc_conf_d;
        cnt_q      <= cnt_d;
        conf_len_q <= conf_len_d;
        grp_pos_q  <= grp_pos_d;
        grp_nz_q   <= grp_nz_d;
        trim_q     <= trim_d;
        await_q    <= await_d;
        att_q      <= att_d;
        final_q    <= final_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

/* dv/download_result_checker.sv */
`timescale 1ns / 1ps

module download_result_checker
  import crcdl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output logic [15:0] line_crc_o
);

  localparam int LineMax   = 1024;
  localparam int GroupLen  = 5;
  localparam int HeaderLen = 3;

  logic [3:0]  attempt_limit;
  logic [15:0] crc_all;
  logic [15:0] crc_kept;
  logic [10:0] bytes_seen;
  logic [10:0] bytes_kept;
  logic [2:0]  grp_pos;
  logic        grp_nonzero;
  logic        trimmed;
  logic        wait_readback;
  logic [3:0]  tries;
  logic        line_final;

  out_item_t   pending_results[$];
  int          n_reported;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    line_crc_o   = '0;
    n_reported   = 0;
  end

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    repeat (8) x = x[15] ? ((x << 1) ^ CrcPoly) : (x << 1);
    return x;
  endfunction

  function automatic logic [9:0] payload_len();
    return (bytes_kept > 0) ? 10'(bytes_kept - 11'd1) : 10'd0;
  endfunction

  task automatic clear_line();
    crc_all       = CrcInit;
    crc_kept      = CrcInit;
    bytes_seen    = '0;
    bytes_kept    = '0;
    grp_pos       = '0;
    grp_nonzero   = 1'b0;
    trimmed       = 1'b0;
    wait_readback = 1'b0;
    tries         = '0;
    line_final    = 1'b0;
  endtask

  task automatic keep_so_far();
    crc_kept   = crc_all;
    bytes_kept = bytes_seen;
  endtask

  // updates the line state for one transaction and queues the result it causes
  task automatic fold_item(input in_item_t it);
    out_item_t   r;
    logic [10:0] pos;
    bit          has;
    r   = '0;
    has = 1'b0;
    if (it.mode == ModeByte) begin
      if (wait_readback) begin
        r.status        = ST_OUT_OF_TURN;
        r.attempt_count = tries;
        has             = 1'b1;
      end else begin
        if (bytes_seen == 0) line_final = it.final_line;
        pos = bytes_seen;
        if (bytes_seen <= LineMax) bytes_seen++;
        if (!trimmed) begin
          crc_all = crc16_fold(crc_all, it.data_byte);
          if (!line_final || pos < HeaderLen) begin
            keep_so_far();
          end else begin
            grp_pos++;
            if (it.data_byte != 8'h00) grp_nonzero = 1'b1;
            if (grp_pos >= GroupLen) begin
              if (grp_nonzero) keep_so_far();
              else trimmed = 1'b1;
              grp_pos     = '0;
              grp_nonzero = 1'b0;
            end
          end
        end
        if (it.last_of_line) begin
          // a partial group at the end of the line is kept
          if (!trimmed && grp_pos > 0) keep_so_far();
          has = 1'b1;
          if (bytes_seen > LineMax) begin
            clear_line();
            r.status = ST_FAILED;
          end else begin
            wait_readback   = 1'b1;
            tries           = 4'd1;
            r.status        = ST_SEND;
            r.expected_crc  = crc_kept;
            r.send_length   = payload_len();
            r.attempt_count = tries;
          end
        end
      end
    end else begin
      has = 1'b1;
      if (!wait_readback) begin
        r.status        = ST_OUT_OF_TURN;
        r.attempt_count = tries;
      end else begin
        r.expected_crc = crc_kept;
        r.send_length  = payload_len();
        if (it.readback_crc == crc_kept) begin
          r.status        = ST_ACCEPTED;
          r.attempt_count = tries;
          clear_line();
        end else if (tries < attempt_limit) begin
          tries++;
          r.status        = ST_RESEND;
          r.attempt_count = tries;
        end else begin
          r.status        = ST_FAILED;
          r.attempt_count = tries;
          clear_line();
        end
      end
    end
    if (has) pending_results.push_back(r);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      fail_count_o++;
      if (n_reported < 10) begin
        $display("%0t: result with nothing expected: status %0d crc %h len %0d att %0d",
                 $time, got.status, got.expected_crc, got.send_length, got.attempt_count);
        n_reported++;
      end
    end else begin
      want = pending_results.pop_front();
      checked_o++;
      if (got.status !== want.status || got.expected_crc !== want.expected_crc ||
          got.send_length !== want.send_length || got.attempt_count !== want.attempt_count) begin
        fail_count_o++;
        if (n_reported < 10) begin
          $display("%0t: mismatch: expected status %0d crc %h len %0d att %0d", $time,
                   want.status, want.expected_crc, want.send_length, want.attempt_count);
          $display("%0t:           actual   status %0d crc %h len %0d att %0d", $time,
                   got.status, got.expected_crc, got.send_length, got.attempt_count);
          n_reported++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attempt_limit = AttemptsReset;
      clear_line();
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) fold_item(in_data_i);
      if (cfg_we_i) attempt_limit = cfg_wdata_i;
    end
    pending_o  = pending_results.size();
    line_crc_o = crc_kept;
  end

endmodule

/* dv/crc_checked_download_verifier_core_test.sv */
`timescale 1ns / 1ps

module crc_checked_download_verifier_core_test;
  import crcdl_pkg::*;

  localparam int RandItems  = 750;
  localparam int HoldCycles = 400;
  localparam int StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  crcdl_in_if  in_if ();
  crcdl_out_if out_if ();

  int          fail_count;
  int          pending;
  int          checked;
  logic [15:0] line_crc;

  bit          idle_on;
  bit          hold_req;
  int          n_items;
  int          n_long;
  int          n_lines;
  int          n_settings;
  int          idle_cycles;
  int          stall_left;
  int          phase;
  int          long_len;
  logic [3:0]  cur_limit;

  always #5 clk = ~clk;

  crc_checked_download_verifier_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  download_result_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .line_crc_o  (line_crc)
  );

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic fin);
    in_item_t it;
    it.mode         = ModeByte;
    it.data_byte    = b;
    it.last_of_line = last;
    it.final_line   = fin;
    it.readback_crc = 16'($urandom);
    push_item(it);
  endtask

  task automatic send_readback(input logic [15:0] v);
    in_item_t it;
    it.mode         = ModeReadback;
    it.data_byte    = 8'($urandom);
    it.last_of_line = 1'($urandom);
    it.final_line   = 1'($urandom);
    it.readback_crc = v;
    push_item(it);
  endtask

  // the sender goes quiet until every result is in, then writes the register
  task automatic write_limit(input logic [3:0] v);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
    n_settings++;
  endtask

  // one download line followed by readbacks until it is accepted or failed
  task automatic run_line(input int len, input bit fin);
    int         k;
    int         eff;
    int         gkind;
    logic [7:0] b;
    gkind = 2;
    n_lines++;
    if ($urandom_range(0, 9) == 0) send_readback(16'($urandom));
    for (int i = 0; i < len; i++) begin
      // on final lines pick a flavor per group so that zero groups are common
      if (fin && i >= 3 && (i - 3) % 5 == 0) gkind = $urandom_range(0, 2);
      if (!fin || i < 3 || gkind == 2) b = 8'($urandom);
      else if (gkind == 0) b = 8'h00;
      else b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00;
      send_byte(b, i == len - 1, (i == 0) ? fin : 1'($urandom));
    end
    if (len <= 1024) begin
      eff = (cur_limit == 0) ? 1 : cur_limit;
      k = ($urandom_range(0, 3) == 0) ? eff : $urandom_range(0, (eff < 3) ? eff : 3);
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'($urandom), 1'($urandom));
        send_readback(line_crc ^ 16'($urandom_range(1, 65535)));
      end
      if (k < eff) send_readback(line_crc);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("crc_checked_download_verifier_core regression: fail");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    n_items     = 0;
    n_long      = 0;
    n_lines     = 0;
    n_settings  = 0;
    cur_limit   = AttemptsReset;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    write_limit(4'd1);
    // readback with no line open
    send_readback(16'hFFFF);
    // command byte only, mismatch fails at once with a limit of one
    send_byte(8'h00, 1'b1, 1'b0);
    send_readback(line_crc ^ 16'h8000);

    write_limit(4'd15);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_readback(~line_crc);
    send_readback(line_crc);
    // final line: zero group after the header ends the counted part
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    repeat (5) send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'h11, 1'b1, 1'b1);
    send_readback(line_crc);
    // final line ending inside a group keeps the partial group
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h07, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_readback(16'h0000);

    phase = 0;
    while (n_items - n_long < RandItems + 25) begin
      if (n_items - n_long > RandItems - 100) idle_on = 1'b0;
      case (phase)
        0: begin
          write_limit(4'd1);
        end
        1: begin
          write_limit(4'd15);
        end
        2: begin
          write_limit(4'd0);
        end
        default: begin
          write_limit(4'($urandom_range(1, 15)));
        end
      endcase
      if (phase == 3) hold_req = 1'b1;
      repeat (6) begin
        run_line(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40),
                 1'($urandom));
      end
      if (phase == 4) begin
        n_long += 1024;
        run_line(1024, 1'b0);
      end
      if (phase == 5) begin
        long_len = 1025 + $urandom_range(0, 20);
        n_long += long_len;
        run_line(long_len, 1'($urandom));
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    $display("covered %0d input transactions over %0d random lines and %0d limit settings",
             n_items, n_lines, n_settings);
    $display("checked %0d results, including two lines at the length limit", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("crc_checked_download_verifier_core regression: pass");
    end else begin
      $display("crc_checked_download_verifier_core regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/crcdl_pkg.sv
rtl/core/crcdl_in_if.sv
rtl/core/crcdl_out_if.sv
rtl/core/crc_checked_download_verifier_core.sv
dv/download_result_checker.sv
dv/crc_checked_download_verifier_core_test.sv
